### rtl/tpcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed predicate compare filter package
// Shared constants, operation and type codes, and the compare result type.
// ----------------------------------------------------------------------------
package tpcf_pkg;

    localparam int unsigned ValueWidth = 64;
    localparam int unsigned OpWidth    = 3;
    localparam int unsigned TypeWidth  = 2;
    localparam int unsigned CfgIdxWidth = 2;

    localparam logic [OpWidth-1:0] OP_EQ = 3'd0;
    localparam logic [OpWidth-1:0] OP_NE = 3'd1;
    localparam logic [OpWidth-1:0] OP_LT = 3'd2;
    localparam logic [OpWidth-1:0] OP_LE = 3'd3;
    localparam logic [OpWidth-1:0] OP_GT = 3'd4;
    localparam logic [OpWidth-1:0] OP_GE = 3'd5;

    localparam logic [TypeWidth-1:0] TYPE_I32 = 2'd0;
    localparam logic [TypeWidth-1:0] TYPE_I64 = 2'd1;
    localparam logic [TypeWidth-1:0] TYPE_F32 = 2'd2;
    localparam logic [TypeWidth-1:0] TYPE_F64 = 2'd3;

    localparam logic [CfgIdxWidth-1:0] REG_COMPARE_OP   = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_VALUE_TYPE   = 2'd1;
    localparam logic [CfgIdxWidth-1:0] REG_LITERAL_BITS = 2'd2;

    // Three-way result of a compare.
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

### rtl/tpcf_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for column values in and match bits out.
// ----------------------------------------------------------------------------
interface tpcf_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;
    logic        prior_match;
    logic        last_in;

    modport source (output valid, value_bits, prior_match, last_in, input ready);
    modport sink   (input valid, value_bits, prior_match, last_in, output ready);
endinterface

interface tpcf_out_if;
    logic valid;
    logic ready;
    logic match_out;
    logic last_out;

    modport source (output valid, match_out, last_out, input ready);
    modport sink   (input valid, match_out, last_out, output ready);
endinterface

### rtl/tpcf_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed compare
// Three-way compare of value and literal as int32, int64, float32 or float64.
// ----------------------------------------------------------------------------
module tpcf_compare (
    input  logic [63:0]       value_bits,
    input  logic [63:0]       literal_bits,
    input  logic [1:0]        value_type,
    output tpcf_pkg::cmp_res_t result
);

    logic        is_float;
    logic        is_wide;
    logic [63:0] a;
    logic [63:0] b;
    logic        a_nan;
    logic        b_nan;
    logic [63:0] ka;
    logic [63:0] kb;
    logic [63:0] mag_a;
    logic [63:0] mag_b;

    assign is_float = (value_type == tpcf_pkg::TYPE_F32) || (value_type == tpcf_pkg::TYPE_F64);
    assign is_wide  = (value_type == tpcf_pkg::TYPE_I64) || (value_type == tpcf_pkg::TYPE_F64);

    // Narrow types are placed in the top half so that one 64-bit compare serves all.
    assign a = is_wide ? value_bits   : {value_bits[31:0], 32'd0};
    assign b = is_wide ? literal_bits : {literal_bits[31:0], 32'd0};

    assign mag_a = {1'b0, a[62:0]};
    assign mag_b = {1'b0, b[62:0]};

    always_comb
    begin
        if (is_wide)
        begin
            a_nan = mag_a > 64'h7FF0_0000_0000_0000;
            b_nan = mag_b > 64'h7FF0_0000_0000_0000;
        end
        else
        begin
            a_nan = mag_a > 64'h7F80_0000_0000_0000;
            b_nan = mag_b > 64'h7F80_0000_0000_0000;
        end
    end

    always_comb
    begin
        if (is_float)
        begin
            // Both zeros map to the same key; negatives are inverted.
            if (mag_a == 64'd0)   ka = 64'h8000_0000_0000_0000;
            else if (a[63])       ka = ~a;
            else                  ka = a | 64'h8000_0000_0000_0000;
            if (mag_b == 64'd0)   kb = 64'h8000_0000_0000_0000;
            else if (b[63])       kb = ~b;
            else                  kb = b | 64'h8000_0000_0000_0000;
        end
        else
        begin
            ka = a ^ 64'h8000_0000_0000_0000;
            kb = b ^ 64'h8000_0000_0000_0000;
        end
    end

    always_comb
    begin
        if (is_float && a_nan)
        begin
            result.eq = b_nan;
            result.lt = 1'b0;
        end
        else if (is_float && b_nan)
        begin
            result.eq = 1'b0;
            result.lt = 1'b1;
        end
        else
        begin
            result.eq = ka == kb;
            result.lt = ka < kb;
        end
    end

endmodule

### rtl/typed_predicate_compare_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed predicate compare filter
// Column filter: match_out = prior_match AND compare(value, literal, op).
// ----------------------------------------------------------------------------
// Channel    Role    Payload
// in_ch      sink    value_bits[63:0], prior_match, last_in
// out_ch     source  match_out, last_out
// cfg        write   cfg_we, cfg_index[1:0], cfg_data[63:0]
//
// One item per cycle while out_ch is not stalled. An input register feeds
// the compare and a result register. The result stage advances when empty or
// taken; the input stage loads when empty too, else waits with the result.
// Reset clears the configuration and both valid bits.
// ----------------------------------------------------------------------------
module typed_predicate_compare_filter (
    input  logic        clk,
    input  logic        rst_n,
    tpcf_in_if.sink     in_ch,
    tpcf_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [2:0]  op_reg;
    logic [1:0]  type_reg;
    logic [63:0] lit_reg;

    logic        s1_valid_reg;
    logic [63:0] s1_value_reg;
    logic        s1_prior_reg;
    logic        s1_last_reg;

    logic        s2_valid_reg;
    logic        s2_match_reg;
    logic        s2_last_reg;

    logic        advance;
    logic        keep;
    logic        match_next;
    tpcf_pkg::cmp_res_t cmp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= tpcf_pkg::OP_EQ;
            type_reg <= tpcf_pkg::TYPE_I32;
            lit_reg  <= 64'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tpcf_pkg::REG_COMPARE_OP:   op_reg   <= cfg_data[2:0];
                tpcf_pkg::REG_VALUE_TYPE:   type_reg <= cfg_data[1:0];
                tpcf_pkg::REG_LITERAL_BITS: lit_reg  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign advance      = !s2_valid_reg || out_ch.ready;
    assign in_ch.ready  = advance || !s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;
            if (advance)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_value_reg <= in_ch.value_bits;
            s1_prior_reg <= in_ch.prior_match;
            s1_last_reg  <= in_ch.last_in;
        end
        if (advance && s1_valid_reg)
        begin
            s2_match_reg <= match_next;
            s2_last_reg  <= s1_last_reg;
        end
    end

    tpcf_compare u_compare (
        .value_bits   (s1_value_reg),
        .literal_bits (lit_reg),
        .value_type   (type_reg),
        .result       (cmp)
    );

    always_comb
    begin
        unique case (op_reg)
            tpcf_pkg::OP_EQ: keep = cmp.eq;
            tpcf_pkg::OP_NE: keep = !cmp.eq;
            tpcf_pkg::OP_LT: keep = cmp.lt;
            tpcf_pkg::OP_LE: keep = cmp.lt || cmp.eq;
            tpcf_pkg::OP_GT: keep = !cmp.lt && !cmp.eq;
            tpcf_pkg::OP_GE: keep = !cmp.lt;
            default:         keep = 1'b0;
        endcase
    end

    assign match_next       = s1_prior_reg && keep;
    assign out_ch.valid     = s2_valid_reg;
    assign out_ch.match_out = s2_match_reg;
    assign out_ch.last_out  = s2_last_reg;

endmodule

### rtl/tpcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filter port checker
// Port-level checks on the typed predicate compare filter.
// ----------------------------------------------------------------------------
module tpcf_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic match_out,
    input logic last_out
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(match_out) && $stable(last_out))
        else $error("result changed while stalled");

    // With the output free, input is always taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Input is only held back by a result that is waiting to be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    // No result appears without an earlier transfer in.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(out_valid, 2))
        else $error("result without input");

endmodule

bind typed_predicate_compare_filter tpcf_checker u_tpcf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .match_out   (out_ch.match_out),
    .last_out    (out_ch.last_out)
);
